### hdl/sha_pkg.sv
// Package for the SHA-256 stream hasher: payload structs, command/status structs,
// round constants and initial hash values. No dependencies.
package sha_pkg;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } out_item_t;

  localparam logic [1:0] MODE_ABSORB = 2'd0;
  localparam logic [1:0] MODE_ABSORB_FINISH = 2'd1;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  // Source of the byte shifted into the block.
  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_PAD  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  // Controller commands to the datapath.
  typedef struct packed {
    logic       shift_byte;   // shift one byte into the block
    logic [1:0] byte_sel;     // which byte is shifted in
    logic [7:0] byte_in;      // message byte for SRC_DATA
    logic       count_inc;    // bump byte counter
    logic       start_comp;   // begin a 64-round compression
    logic       reinit;       // restore IV and clear counter
  } sha_cmd_t;

  typedef struct packed {
    logic       busy;         // compression running
    logic [5:0] pos;          // byte position in block
  } sha_stat_t;

  localparam logic [255:0] IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

### hdl/sha_datapath.sv
// SHA-256 datapath: block shift register doubling as schedule window, round unit,
// chaining words and byte counter. Depends on sha_pkg.
module sha_datapath (
  input  logic               clk,
  input  logic               rst,
  input  sha_pkg::sha_cmd_t  cmd,
  output sha_pkg::sha_stat_t stat,
  output logic [255:0]       chain
);

  // Bytes are shifted in at the low end; after 64 bytes word 0 sits at the top.
  // During compression the same register shifts one word per round.
  logic [511:0] sched;
  logic [63:0]  byte_count;
  logic [255:0] chain_words;
  logic [31:0]  va, vb, vc, vd, ve, vf, vg, vh;
  logic [5:0]   round;
  logic [5:0]   fill;
  logic         busy;
  logic         fold;

  logic [63:0] bits;
  logic [7:0]  len_byte;
  logic [7:0]  fill_byte;
  logic [31:0] w0, w1, w9, w14;
  logic [31:0] t1, t2, s0, s1, w_new;

  assign bits = {byte_count[60:0], 3'b000};
  // Length bytes go most significant first into positions 56 to 63.
  assign len_byte = bits[{~fill[2:0], 3'b000} +: 8];
  assign stat = '{busy: busy, pos: fill};
  assign chain = chain_words;

  always_comb begin
    case (cmd.byte_sel)
      sha_pkg::SRC_DATA: fill_byte = cmd.byte_in;
      sha_pkg::SRC_PAD:  fill_byte = sha_pkg::PAD_BYTE;
      sha_pkg::SRC_LEN:  fill_byte = len_byte;
      sha_pkg::SRC_ZERO: fill_byte = 8'h00;
      default:           fill_byte = 8'h00;
    endcase
  end

  assign w0  = sched[511:480];
  assign w1  = sched[479:448];
  assign w9  = sched[223:192];
  assign w14 = sched[63:32];
  assign s0 = sha_pkg::rotr(w1, 7) ^ sha_pkg::rotr(w1, 18) ^ (w1 >> 3);
  assign s1 = sha_pkg::rotr(w14, 17) ^ sha_pkg::rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  assign t1 = vh + (sha_pkg::rotr(ve, 6) ^ sha_pkg::rotr(ve, 11) ^ sha_pkg::rotr(ve, 25))
            + ((ve & vf) ^ (~ve & vg)) + sha_pkg::RK[round] + w0;
  assign t2 = (sha_pkg::rotr(va, 2) ^ sha_pkg::rotr(va, 13) ^ sha_pkg::rotr(va, 22))
            + ((va & vb) ^ (va & vc) ^ (vb & vc));

  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      sched <= {sched[503:0], fill_byte};
    end else if (busy && !fold) begin
      sched <= {sched[479:0], w_new};
    end
    if (cmd.start_comp) begin
      {va, vb, vc, vd, ve, vf, vg, vh} <= chain_words;
    end else if (busy && !fold) begin
      vh <= vg; vg <= vf; vf <= ve; ve <= vd + t1;
      vd <= vc; vc <= vb; vb <= va; va <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      fold        <= 1'b0;
      round       <= '0;
      fill        <= '0;
      byte_count  <= '0;
      chain_words <= sha_pkg::IV;
    end else begin
      if (cmd.shift_byte) begin
        fill <= fill + 6'd1;
      end
      if (cmd.reinit) begin
        byte_count <= '0;
      end else if (cmd.count_inc) begin
        byte_count <= byte_count + 64'd1;
      end
      if (cmd.start_comp) begin
        busy  <= 1'b1;
        fold  <= 1'b0;
        round <= '0;
      end else if (fold) begin
        busy <= 1'b0;
        fold <= 1'b0;
      end else if (busy) begin
        round <= round + 6'd1;
        if (round == 6'd63) begin
          fold <= 1'b1;
        end
      end
      // The working words are added into the chain in the cycle after the last round.
      if (cmd.reinit) begin
        chain_words <= sha_pkg::IV;
      end else if (fold) begin
        chain_words <= {chain_words[255:224] + va,
                        chain_words[223:192] + vb,
                        chain_words[191:160] + vc,
                        chain_words[159:128] + vd,
                        chain_words[127:96]  + ve,
                        chain_words[95:64]   + vf,
                        chain_words[63:32]   + vg,
                        chain_words[31:0]    + vh};
      end
    end
  end

endmodule

### hdl/sha_ctrl.sv
// SHA-256 controller: sequences absorb, padding, compressions and digest output.
// Depends on sha_pkg.
module sha_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sha_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sha_pkg::out_item_t   out_item,
  input  sha_pkg::sha_stat_t   stat,
  input  logic [255:0]         chain,
  output sha_pkg::sha_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_COMP  = 3'd1;  // compression of a full message block
  localparam logic [2:0] ST_PAD   = 3'd2;  // pad, zero and length bytes
  localparam logic [2:0] ST_PCOMP = 3'd3;  // compression of a padding block
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]   state, state_next;
  logic [2:0]   idx;
  logic [255:0] dig;
  logic         fin_pend;   // finish follows the running block compression
  logic         pad_first;  // next padding byte is the 0x80 marker
  logic         len_blk;    // current padding block carries the length
  logic         acc;
  logic         has_byte;

  assign in_ready = (state == ST_IDLE);
  assign acc = in_valid && in_ready;
  assign has_byte = in_item.mode inside {sha_pkg::MODE_ABSORB, sha_pkg::MODE_ABSORB_FINISH};
  assign out_valid = (state == ST_OUT);
  assign out_item = '{digest_word: dig[255:224], word_index: idx, last: (idx == 3'd7)};

  always_comb begin
    cmd = '0;
    cmd.byte_in = in_item.data_byte;
    cmd.byte_sel = sha_pkg::SRC_DATA;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (has_byte) begin
            cmd.shift_byte = 1'b1;
            cmd.count_inc  = 1'b1;
            if (stat.pos == 6'd63) begin
              cmd.start_comp = 1'b1;
              state_next = ST_COMP;
            end else if (in_item.mode == sha_pkg::MODE_ABSORB_FINISH) begin
              state_next = ST_PAD;
            end
          end else begin
            state_next = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        if (!stat.busy) begin
          state_next = fin_pend ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        cmd.shift_byte = 1'b1;
        if (pad_first) begin
          cmd.byte_sel = sha_pkg::SRC_PAD;
        end else if (len_blk && stat.pos >= sha_pkg::LEN_POS) begin
          cmd.byte_sel = sha_pkg::SRC_LEN;
        end else begin
          cmd.byte_sel = sha_pkg::SRC_ZERO;
        end
        if (stat.pos == 6'd63) begin
          cmd.start_comp = 1'b1;
          state_next = ST_PCOMP;
        end
      end
      ST_PCOMP: begin
        if (!stat.busy) begin
          if (len_blk) begin
            cmd.reinit = 1'b1;
            state_next = ST_OUT;
          end else begin
            state_next = ST_PAD;
          end
        end
      end
      ST_OUT: begin
        if (out_ready && idx == 3'd7) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      fin_pend  <= 1'b0;
      pad_first <= 1'b0;
      len_blk   <= 1'b0;
    end else begin
      state <= state_next;
      if (acc) begin
        fin_pend <= (in_item.mode == sha_pkg::MODE_ABSORB_FINISH);
      end
      if (state == ST_PAD) begin
        pad_first <= 1'b0;
      end else if (state_next == ST_PAD && state != ST_PCOMP) begin
        pad_first <= 1'b1;
      end
      // The length fits behind the marker only if the marker lands before byte 56.
      if (state == ST_PAD && pad_first) begin
        len_blk <= (stat.pos < sha_pkg::LEN_POS);
      end else if (state == ST_PCOMP && !stat.busy) begin
        len_blk <= 1'b1;
      end
      if (state == ST_OUT && out_ready) begin
        idx <= idx + 3'd1;
      end
    end
  end

  // Digest snapshot is taken as the chaining words are reset, then shifted out.
  always_ff @(posedge clk) begin
    if (cmd.reinit) begin
      dig <= chain;
    end else if (state == ST_OUT && out_ready) begin
      dig <= {dig[223:0], 32'h0};
    end
  end

endmodule

### hdl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: joins controller and datapath.
// Depends on sha_pkg, sha_ctrl and sha_datapath.
//
// Usage: each input transaction carries mode and data_byte. Mode 0 absorbs a
// byte, mode 1 absorbs a byte and finishes, modes 2 and 3 finish with no byte.
// A finish produces eight output transactions carrying the digest words, most
// significant first, with last set on the eighth; the hasher then restarts.
// Throughput: bytes inside a block are taken one per cycle. The byte that
// completes a block starts a compression of 64 rounds and a final step that
// adds into the chaining words; in_ready stays low until that has finished.
// Finish: after a finishing transaction the padding bytes are written one per
// cycle up to the end of the block, followed by a compression. A marker at
// byte 56 or later adds a second padding block and its compression, and a
// mode 1 byte that completes a block adds the compression of that block. One
// digest word moves per cycle while out_ready is high. in_ready is low from
// the finish until the eighth word is taken.
// Reset restores the initial hash values and clears the byte counter. When the
// receiver stalls, the current digest word holds until taken and no new input
// is accepted.
module sha256_stream_hasher (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sha_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sha_pkg::out_item_t out_data
);

  sha_pkg::sha_cmd_t  cmd;
  sha_pkg::sha_stat_t stat;
  logic [255:0]       chain;

  sha_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_item(out_data), .stat(stat), .chain(chain), .cmd(cmd)
  );

  sha_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .chain(chain)
  );

endmodule

### bench/sha256_digest_checker.sv
// Checker for the SHA-256 stream hasher: watches both channels, predicts the
// digest words of each finished message and compares them. Depends on sha_pkg.
module sha256_digest_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  sha_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  sha_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]        hash_state [8];
  logic [7:0]         msg_block [64];
  logic [63:0]        msg_len;
  sha_pkg::out_item_t digest_queue [$];

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RK[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::IV[255 - 32*i -: 32];
    msg_len = '0;
  endtask

  task automatic hash_transaction(sha_pkg::in_item_t item);
    int pos;
    logic [63:0] bits;
    sha_pkg::out_item_t word;
    if (item.mode == sha_pkg::MODE_ABSORB || item.mode == sha_pkg::MODE_ABSORB_FINISH) begin
      pos = int'(msg_len[5:0]);
      msg_block[pos] = item.data_byte;
      msg_len++;
      if (pos == 63) compress_block();
    end
    if (item.mode == sha_pkg::MODE_ABSORB) return;
    // Any other mode, including the unused code three, finishes the message.
    pos = int'(msg_len[5:0]);
    bits = msg_len << 3;
    msg_block[pos++] = sha_pkg::PAD_BYTE;
    if (pos > sha_pkg::LEN_POS) begin
      for (int i = pos; i < 64; i++) msg_block[i] = '0;
      compress_block();
      pos = 0;
    end
    for (int i = pos; i < sha_pkg::LEN_POS; i++) msg_block[i] = '0;
    for (int i = 0; i < 8; i++) msg_block[sha_pkg::LEN_POS + i] = bits[63 - 8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      word.digest_word = hash_state[i];
      word.word_index = 3'(i);
      word.last = (i == 7);
      digest_queue.push_back(word);
    end
    restart_message();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    sha_pkg::out_item_t want;
    if (rst) begin
      restart_message();
      digest_queue.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) hash_transaction(in_data);
      if (out_valid && out_ready) begin
        if (digest_queue.size() == 0) begin
          report_mismatch("unexpected transaction", out_data.digest_word, '0);
        end else begin
          want = digest_queue.pop_front();
          if (out_data.digest_word !== want.digest_word)
            report_mismatch("digest_word", out_data.digest_word, want.digest_word);
          if (out_data.word_index !== want.word_index)
            report_mismatch("word_index", out_data.word_index, want.word_index);
          if (out_data.last !== want.last)
            report_mismatch("last", out_data.last, want.last);
        end
      end
    end
    pending_words = digest_queue.size();
  end
endmodule

### bench/tb_sha256_stream_hasher.sv
// Testbench top for the SHA-256 stream hasher: drives message transactions with
// random gaps and stalls and gives the verdict. Depends on sha_pkg, the hasher and the checker.
module tb_sha256_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_FINISH = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 370;

  logic               clk, rst;
  logic               in_valid, in_ready, out_valid, out_ready;
  sha_pkg::in_item_t  in_data;
  sha_pkg::out_item_t out_data;
  int                 fail_count, pending_words;
  int                 cycle_count;
  int                 items_sent;
  bit                 hold_receiver;   // set while the receiver is forced to stall
  bit                 stimulus_done;

  sha256_stream_hasher dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));

  sha256_digest_checker checker_i (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_words(pending_words));

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Gap lengths are mostly short; now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Offers one transaction and holds it until the hasher takes it. The valid
  // line stays high when the next transaction follows with no gap.
  task automatic send_byte(logic [1:0] mode, logic [7:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{mode: mode, data_byte: value};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // A message of random bytes closed by one of the finishing modes.
  task automatic send_message(int len, logic [1:0] closing);
    int body;
    body = (closing == sha_pkg::MODE_ABSORB_FINISH && len > 0) ? len - 1 : len;
    for (int i = 0; i < body; i++) send_byte(sha_pkg::MODE_ABSORB, 8'($urandom));
    send_byte((closing == sha_pkg::MODE_ABSORB_FINISH && len == 0) ? MODE_FINISH : closing,
              8'($urandom));
  endtask

  function automatic logic [1:0] pick_closing();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return sha_pkg::MODE_ABSORB_FINISH;
    if (r < 9) return MODE_FINISH;
    return MODE_SPARE;
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long forced hold when asked.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_receiver) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Cycle counter and timeout.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("tb_sha256_stream_hasher failed");
        $finish;
      end
    end
  end

  // Long receiver hold-off, counted in its own process, while stimulus goes on.
  initial begin
    hold_receiver = 1'b0;
    wait (stimulus_done === 1'b0);
    @(posedge clk);
    while (rst) @(posedge clk);
    repeat (40) @(posedge clk);
    hold_receiver = 1'b1;
    repeat (600) @(posedge clk);
    hold_receiver = 1'b0;
  end

  initial begin
    int len;
    stimulus_done = 1'b0;
    items_sent = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty message, the spare mode, field extremes and the padding
    // boundaries around the point where the length spills into a second block.
    send_byte(MODE_FINISH, 8'hff);
    send_byte(MODE_SPARE, 8'h00);
    send_byte(sha_pkg::MODE_ABSORB_FINISH, 8'h00);
    send_byte(sha_pkg::MODE_ABSORB_FINISH, 8'hff);
    send_byte(sha_pkg::MODE_ABSORB, 8'h61);
    send_byte(sha_pkg::MODE_ABSORB, 8'h62);
    send_byte(sha_pkg::MODE_ABSORB_FINISH, 8'h63);
    send_byte(sha_pkg::MODE_ABSORB, 8'h00);
    send_byte(sha_pkg::MODE_ABSORB, 8'hff);
    send_byte(sha_pkg::MODE_ABSORB, 8'haa);
    send_byte(sha_pkg::MODE_ABSORB, 8'h55);
    send_byte(MODE_FINISH, 8'h00);
    send_message(55, sha_pkg::MODE_ABSORB_FINISH);
    send_message(56, MODE_FINISH);
    send_message(64, sha_pkg::MODE_ABSORB_FINISH);

    // The sender pauses until every expected digest word has come.
    drain_results();

    // Random part: mostly short messages, some crossing block boundaries.
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 7) len = $urandom_range(0, 12);
      else len = $urandom_range(50, 130);
      if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
      send_message(len, pick_closing());
    end
    in_valid <= 1'b0;
    stimulus_done = 1'b1;

    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("tb_sha256_stream_hasher passed");
    end else begin
      $display("tb_sha256_stream_hasher failed");
    end
    $finish;
  end
endmodule

### sha256_stream_hasher.f
hdl/sha_pkg.sv
hdl/sha_datapath.sv
hdl/sha_ctrl.sv
hdl/sha256_stream_hasher.sv
bench/sha256_digest_checker.sv
bench/tb_sha256_stream_hasher.sv
